>>> hdl/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared opcodes, function codes, mnemonic and format codes of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvdec_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_MISC   = 7'h0F;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_IMM32  = 7'h1B;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_REG32  = 7'h3B;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_U    = 3'd5,
        FMT_J    = 3'd6
    } t_fmt;

    typedef enum logic [5:0] {
        MN_UNK = 6'd0, MN_WIDE,
        MN_LUI, MN_AUIPC, MN_JAL, MN_JALR,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_LB, MN_LW, MN_LH, MN_LBU, MN_LHU, MN_SB, MN_SW, MN_SH,
        MN_ADDI, MN_SLTI, MN_SLTIU, MN_XORI, MN_ORI, MN_ANDI,
        MN_SLLI, MN_SRLI, MN_SRAI,
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA,
        MN_OR, MN_AND,
        MN_FENCE, MN_FENCE_I, MN_ECALL, MN_EBREAK,
        MN_CSRRW, MN_CSRRS, MN_CSRRC, MN_CSRRWI, MN_CSRRSI, MN_CSRRCI,
        MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV, MN_DIVU, MN_REM, MN_REMU
    } t_mnem;

endpackage

`default_nettype wire

>>> hdl/rvdec_mnem.sv
// ----------------------------------------------------------------------------
// rvdec_mnem
// Maps opcode, funct3, funct7 and the system field to a mnemonic code.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_mnem (
    input  wire logic [31:0]      i_word,
    output rvdec_pkg::t_mnem      o_mnem
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] top12;

    assign opc   = i_word[6:0];
    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign top12 = i_word[31:20];

    always_comb begin
        o_mnem = rvdec_pkg::MN_UNK;
        case (opc)
            rvdec_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_LB;
                    3'd1: o_mnem = rvdec_pkg::MN_LH;
                    3'd2: o_mnem = rvdec_pkg::MN_LW;
                    3'd3: o_mnem = rvdec_pkg::MN_WIDE;
                    3'd4: o_mnem = rvdec_pkg::MN_LBU;
                    3'd5: o_mnem = rvdec_pkg::MN_LHU;
                    3'd6: o_mnem = rvdec_pkg::MN_WIDE;
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_STORE: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_SB;
                    3'd1: o_mnem = rvdec_pkg::MN_SH;
                    3'd2: o_mnem = rvdec_pkg::MN_SW;
                    3'd3: o_mnem = rvdec_pkg::MN_WIDE;
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_BEQ;
                    3'd1: o_mnem = rvdec_pkg::MN_BNE;
                    3'd4: o_mnem = rvdec_pkg::MN_BLT;
                    3'd5: o_mnem = rvdec_pkg::MN_BGE;
                    3'd6: o_mnem = rvdec_pkg::MN_BLTU;
                    3'd7: o_mnem = rvdec_pkg::MN_BGEU;
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_MISC: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_FENCE;
                    3'd1: o_mnem = rvdec_pkg::MN_FENCE_I;
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_JALR: begin
                if (f3 == 3'd0) begin
                    o_mnem = rvdec_pkg::MN_JALR;
                end
            end
            rvdec_pkg::OPC_AUIPC: o_mnem = rvdec_pkg::MN_AUIPC;
            rvdec_pkg::OPC_LUI:   o_mnem = rvdec_pkg::MN_LUI;
            rvdec_pkg::OPC_JAL:   o_mnem = rvdec_pkg::MN_JAL;
            rvdec_pkg::OPC_SYSTEM: begin
                case (f3)
                    3'd0: begin
                        if (top12 == rvdec_pkg::SYS_ECALL) begin
                            o_mnem = rvdec_pkg::MN_ECALL;
                        end else if (top12 == rvdec_pkg::SYS_EBREAK) begin
                            o_mnem = rvdec_pkg::MN_EBREAK;
                        end
                    end
                    3'd1: o_mnem = rvdec_pkg::MN_CSRRW;
                    3'd2: o_mnem = rvdec_pkg::MN_CSRRS;
                    3'd3: o_mnem = rvdec_pkg::MN_CSRRC;
                    3'd5: o_mnem = rvdec_pkg::MN_CSRRWI;
                    3'd6: o_mnem = rvdec_pkg::MN_CSRRSI;
                    3'd7: o_mnem = rvdec_pkg::MN_CSRRCI;
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_IMM: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_ADDI;
                    3'd1: begin
                        if (f7 == rvdec_pkg::F7_BASE) begin
                            o_mnem = rvdec_pkg::MN_SLLI;
                        end
                    end
                    3'd2: o_mnem = rvdec_pkg::MN_SLTI;
                    3'd3: o_mnem = rvdec_pkg::MN_SLTIU;
                    3'd4: o_mnem = rvdec_pkg::MN_XORI;
                    3'd5: begin
                        if (f7 == rvdec_pkg::F7_BASE) begin
                            o_mnem = rvdec_pkg::MN_SRLI;
                        end else if (f7 == rvdec_pkg::F7_ALT) begin
                            o_mnem = rvdec_pkg::MN_SRAI;
                        end
                    end
                    3'd6: o_mnem = rvdec_pkg::MN_ORI;
                    default: o_mnem = rvdec_pkg::MN_ANDI;
                endcase
            end
            rvdec_pkg::OPC_IMM32: begin
                case (f3)
                    3'd0: o_mnem = rvdec_pkg::MN_WIDE;
                    3'd1: begin
                        if (f7 == rvdec_pkg::F7_BASE) begin
                            o_mnem = rvdec_pkg::MN_WIDE;
                        end
                    end
                    3'd5: begin
                        if (f7 == rvdec_pkg::F7_BASE || f7 == rvdec_pkg::F7_ALT) begin
                            o_mnem = rvdec_pkg::MN_WIDE;
                        end
                    end
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_REG: begin
                if (f7 == rvdec_pkg::F7_BASE) begin
                    case (f3)
                        3'd0: o_mnem = rvdec_pkg::MN_ADD;
                        3'd1: o_mnem = rvdec_pkg::MN_SLL;
                        3'd2: o_mnem = rvdec_pkg::MN_SLT;
                        3'd3: o_mnem = rvdec_pkg::MN_SLTU;
                        3'd4: o_mnem = rvdec_pkg::MN_XOR;
                        3'd5: o_mnem = rvdec_pkg::MN_SRL;
                        3'd6: o_mnem = rvdec_pkg::MN_OR;
                        default: o_mnem = rvdec_pkg::MN_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_MULDIV) begin
                    case (f3)
                        3'd0: o_mnem = rvdec_pkg::MN_MUL;
                        3'd1: o_mnem = rvdec_pkg::MN_MULH;
                        3'd2: o_mnem = rvdec_pkg::MN_MULHSU;
                        3'd3: o_mnem = rvdec_pkg::MN_MULHU;
                        3'd4: o_mnem = rvdec_pkg::MN_DIV;
                        3'd5: o_mnem = rvdec_pkg::MN_DIVU;
                        3'd6: o_mnem = rvdec_pkg::MN_REM;
                        default: o_mnem = rvdec_pkg::MN_REMU;
                    endcase
                end else if (f7 == rvdec_pkg::F7_ALT) begin
                    case (f3)
                        3'd0: o_mnem = rvdec_pkg::MN_SUB;
                        3'd5: o_mnem = rvdec_pkg::MN_SRA;
                        default: o_mnem = rvdec_pkg::MN_UNK;
                    endcase
                end
            end
            rvdec_pkg::OPC_REG32: begin
                case (f3)
                    3'd0, 3'd5: begin
                        if (f7 == rvdec_pkg::F7_BASE || f7 == rvdec_pkg::F7_ALT) begin
                            o_mnem = rvdec_pkg::MN_WIDE;
                        end
                    end
                    3'd1: begin
                        if (f7 == rvdec_pkg::F7_BASE) begin
                            o_mnem = rvdec_pkg::MN_WIDE;
                        end
                    end
                    default: o_mnem = rvdec_pkg::MN_UNK;
                endcase
            end
            default: o_mnem = rvdec_pkg::MN_UNK;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rvdec_imm.sv
// ----------------------------------------------------------------------------
// rvdec_imm
// Finds the format class from the opcode and assembles its immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_imm (
    input  wire logic [31:0]      i_word,
    output rvdec_pkg::t_fmt       o_fmt,
    output logic signed [31:0]    o_imm
);

    logic s;

    assign s = i_word[31];

    always_comb begin
        case (i_word[6:0])
            rvdec_pkg::OPC_LOAD, rvdec_pkg::OPC_MISC, rvdec_pkg::OPC_IMM,
            rvdec_pkg::OPC_IMM32, rvdec_pkg::OPC_JALR, rvdec_pkg::OPC_SYSTEM:
                o_fmt = rvdec_pkg::FMT_I;
            rvdec_pkg::OPC_AUIPC, rvdec_pkg::OPC_LUI:
                o_fmt = rvdec_pkg::FMT_U;
            rvdec_pkg::OPC_STORE:
                o_fmt = rvdec_pkg::FMT_S;
            rvdec_pkg::OPC_REG, rvdec_pkg::OPC_REG32:
                o_fmt = rvdec_pkg::FMT_R;
            rvdec_pkg::OPC_BRANCH:
                o_fmt = rvdec_pkg::FMT_B;
            rvdec_pkg::OPC_JAL:
                o_fmt = rvdec_pkg::FMT_J;
            default:
                o_fmt = rvdec_pkg::FMT_NONE;
        endcase
    end

    // Register-register and unrecognized opcodes carry no immediate.
    always_comb begin
        case (o_fmt)
            rvdec_pkg::FMT_I: o_imm = {{21{s}}, i_word[30:20]};
            rvdec_pkg::FMT_S: o_imm = {{21{s}}, i_word[30:25], i_word[11:7]};
            rvdec_pkg::FMT_B: o_imm = {{20{s}}, i_word[7], i_word[30:25], i_word[11:8], 1'b0};
            rvdec_pkg::FMT_U: o_imm = {i_word[31:12], 12'h000};
            rvdec_pkg::FMT_J: o_imm = {{12{s}}, i_word[19:12], i_word[20], i_word[30:21], 1'b0};
            default:          o_imm = 32'sd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rv32im_instruction_decoder.sv
// An accepted word goes to the instruction register, then its decode to the result register.
// Throughput: one request per cycle, limited only by the output stall.
// The decode is one pass of shallow logic between the input and result registers.
// Reset clears both valid flags; the block accepts requests the cycle after reset.
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// Two-stage RV32IM decoder: instruction register, decode logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32im_instruction_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // Request channel: one raw instruction word per request.
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [31:0]        i_instruction_word,

    // Result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [5:0]              o_mnemonic_code,
    output logic [2:0]              o_format_class,
    output logic [4:0]              o_dest_reg,
    output logic [4:0]              o_src1_reg,
    output logic [4:0]              o_src2_reg,
    output logic signed [31:0]      o_immediate
);

    // Stage one holds the incoming word; stage two holds the decoded result.
    logic                r_in_valid;
    logic [31:0]         r_word;
    logic                r_out_valid;
    rvdec_pkg::t_mnem    r_mnem;
    rvdec_pkg::t_fmt     r_fmt;
    logic [4:0]          r_rd;
    logic [4:0]          r_rs1;
    logic [4:0]          r_rs2;
    logic signed [31:0]  r_imm;

    logic                n_in_valid;
    logic                n_out_valid;

    rvdec_pkg::t_mnem    dec_mnem;
    rvdec_pkg::t_fmt     dec_fmt;
    logic signed [31:0]  dec_imm;

    // The result register may load when it is empty or its content leaves
    // this cycle. The input register may load when it is empty or its word
    // moves on into the result register, so both stages run every cycle
    // while the downstream side takes results.
    logic out_load;
    logic in_load;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    assign n_in_valid  = in_load  ? i_in_valid : r_in_valid;
    assign n_out_valid = out_load ? r_in_valid : r_out_valid;

    rvdec_mnem u_mnem (
        .i_word (r_word),
        .o_mnem (dec_mnem)
    );

    rvdec_imm u_imm (
        .i_word (r_word),
        .o_fmt  (dec_fmt),
        .o_imm  (dec_imm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_word <= i_instruction_word;
        end
    end

    // Register fields pass straight through from the raw word.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mnem <= dec_mnem;
            r_fmt  <= dec_fmt;
            r_rd   <= r_word[11:7];
            r_rs1  <= r_word[19:15];
            r_rs2  <= r_word[24:20];
            r_imm  <= dec_imm;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mnemonic_code = r_mnem;
    assign o_format_class  = r_fmt;
    assign o_dest_reg      = r_rd;
    assign o_src1_reg      = r_rs1;
    assign o_src2_reg      = r_rs2;
    assign o_immediate     = r_imm;

    // The input side only stalls when a held result is blocked downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A word in stage one that may advance shows up as a result next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_load) |=> o_out_valid)
        else $error("decoded word lost between stages");

    // A recognized mnemonic always comes with a known format.
    a_mnem_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mnem != rvdec_pkg::MN_UNK) |-> (r_fmt != rvdec_pkg::FMT_NONE))
        else $error("known mnemonic with unknown format");

    // Register-register and unknown formats carry a zero immediate.
    a_imm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_fmt == rvdec_pkg::FMT_R || r_fmt == rvdec_pkg::FMT_NONE))
        |-> (r_imm == 32'sd0))
        else $error("nonzero immediate for a format without one");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the RV32IM instruction decoder against a predictor of its own. A
// short list of hand-picked instruction words comes first, then random words,
// most of them well-formed with a real opcode and biased funct7/system fields.
// Both channels idle at random in the first two phases; every result is
// checked field by field in request order.
// ----------------------------------------------------------------------------

// One decoded instruction as the result channel presents it.
typedef struct {
    logic [5:0]         mnem;
    logic [2:0]         fmt;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
} t_decoded_instr;

// Holds the decodes still owed by the block, in request order, and checks
// each arriving result against the oldest of them.
class t_decode_scoreboard;
    t_decoded_instr owed_decodes[$];
    int unsigned    errors;
    int unsigned    checked;
    bit             mnem_seen[64];

    // Decode one instruction word the way the block is meant to.
    function t_decoded_instr decode_word(logic [31:0] word);
        t_decoded_instr     d;
        rvdec_pkg::t_mnem   mn;
        rvdec_pkg::t_fmt    fm;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [6:0]         f7;
        opc = word[6:0];
        f3  = word[14:12];
        f7  = word[31:25];
        mn  = rvdec_pkg::MN_UNK;

        case (opc)
            rvdec_pkg::OPC_LOAD, rvdec_pkg::OPC_MISC, rvdec_pkg::OPC_IMM,
            rvdec_pkg::OPC_IMM32, rvdec_pkg::OPC_JALR, rvdec_pkg::OPC_SYSTEM:
                fm = rvdec_pkg::FMT_I;
            rvdec_pkg::OPC_AUIPC, rvdec_pkg::OPC_LUI: fm = rvdec_pkg::FMT_U;
            rvdec_pkg::OPC_STORE:                     fm = rvdec_pkg::FMT_S;
            rvdec_pkg::OPC_REG, rvdec_pkg::OPC_REG32: fm = rvdec_pkg::FMT_R;
            rvdec_pkg::OPC_BRANCH:                    fm = rvdec_pkg::FMT_B;
            rvdec_pkg::OPC_JAL:                       fm = rvdec_pkg::FMT_J;
            default:                                  fm = rvdec_pkg::FMT_NONE;
        endcase

        case (opc)
            rvdec_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0: mn = rvdec_pkg::MN_LB;
                    3'd1: mn = rvdec_pkg::MN_LH;
                    3'd2: mn = rvdec_pkg::MN_LW;
                    3'd3, 3'd6: mn = rvdec_pkg::MN_WIDE;
                    3'd4: mn = rvdec_pkg::MN_LBU;
                    3'd5: mn = rvdec_pkg::MN_LHU;
                    default: mn = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_STORE: begin
                case (f3)
                    3'd0: mn = rvdec_pkg::MN_SB;
                    3'd1: mn = rvdec_pkg::MN_SH;
                    3'd2: mn = rvdec_pkg::MN_SW;
                    3'd3: mn = rvdec_pkg::MN_WIDE;
                    default: mn = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0: mn = rvdec_pkg::MN_BEQ;
                    3'd1: mn = rvdec_pkg::MN_BNE;
                    3'd4: mn = rvdec_pkg::MN_BLT;
                    3'd5: mn = rvdec_pkg::MN_BGE;
                    3'd6: mn = rvdec_pkg::MN_BLTU;
                    3'd7: mn = rvdec_pkg::MN_BGEU;
                    default: mn = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_MISC: begin
                if (f3 == 3'd0) mn = rvdec_pkg::MN_FENCE;
                else if (f3 == 3'd1) mn = rvdec_pkg::MN_FENCE_I;
            end
            rvdec_pkg::OPC_JALR: begin
                if (f3 == 3'd0) mn = rvdec_pkg::MN_JALR;
            end
            rvdec_pkg::OPC_AUIPC: mn = rvdec_pkg::MN_AUIPC;
            rvdec_pkg::OPC_LUI:   mn = rvdec_pkg::MN_LUI;
            rvdec_pkg::OPC_JAL:   mn = rvdec_pkg::MN_JAL;
            rvdec_pkg::OPC_SYSTEM: begin
                // With funct3 zero the whole upper 12 bits pick ecall or ebreak.
                case (f3)
                    3'd0: begin
                        if (word[31:20] == rvdec_pkg::SYS_ECALL) mn = rvdec_pkg::MN_ECALL;
                        else if (word[31:20] == rvdec_pkg::SYS_EBREAK) begin
                            mn = rvdec_pkg::MN_EBREAK;
                        end
                    end
                    3'd1: mn = rvdec_pkg::MN_CSRRW;
                    3'd2: mn = rvdec_pkg::MN_CSRRS;
                    3'd3: mn = rvdec_pkg::MN_CSRRC;
                    3'd5: mn = rvdec_pkg::MN_CSRRWI;
                    3'd6: mn = rvdec_pkg::MN_CSRRSI;
                    3'd7: mn = rvdec_pkg::MN_CSRRCI;
                    default: mn = rvdec_pkg::MN_UNK;
                endcase
            end
            rvdec_pkg::OPC_IMM: begin
                case (f3)
                    3'd0: mn = rvdec_pkg::MN_ADDI;
                    3'd1: mn = (f7 == rvdec_pkg::F7_BASE) ? rvdec_pkg::MN_SLLI
                                                          : rvdec_pkg::MN_UNK;
                    3'd2: mn = rvdec_pkg::MN_SLTI;
                    3'd3: mn = rvdec_pkg::MN_SLTIU;
                    3'd4: mn = rvdec_pkg::MN_XORI;
                    3'd5: begin
                        if (f7 == rvdec_pkg::F7_BASE) mn = rvdec_pkg::MN_SRLI;
                        else if (f7 == rvdec_pkg::F7_ALT) mn = rvdec_pkg::MN_SRAI;
                    end
                    3'd6: mn = rvdec_pkg::MN_ORI;
                    default: mn = rvdec_pkg::MN_ANDI;
                endcase
            end
            rvdec_pkg::OPC_IMM32: begin
                if (f3 == 3'd0) mn = rvdec_pkg::MN_WIDE;
                else if (f3 == 3'd1 && f7 == rvdec_pkg::F7_BASE) mn = rvdec_pkg::MN_WIDE;
                else if (f3 == 3'd5 &&
                         (f7 == rvdec_pkg::F7_BASE || f7 == rvdec_pkg::F7_ALT)) begin
                    mn = rvdec_pkg::MN_WIDE;
                end
            end
            rvdec_pkg::OPC_REG: begin
                if (f7 == rvdec_pkg::F7_BASE) begin
                    case (f3)
                        3'd0: mn = rvdec_pkg::MN_ADD;
                        3'd1: mn = rvdec_pkg::MN_SLL;
                        3'd2: mn = rvdec_pkg::MN_SLT;
                        3'd3: mn = rvdec_pkg::MN_SLTU;
                        3'd4: mn = rvdec_pkg::MN_XOR;
                        3'd5: mn = rvdec_pkg::MN_SRL;
                        3'd6: mn = rvdec_pkg::MN_OR;
                        default: mn = rvdec_pkg::MN_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_MULDIV) begin
                    // The eight M-extension codes are contiguous in funct3 order.
                    mn = rvdec_pkg::t_mnem'(rvdec_pkg::MN_MUL + f3);
                end else if (f7 == rvdec_pkg::F7_ALT) begin
                    if (f3 == 3'd0) mn = rvdec_pkg::MN_SUB;
                    else if (f3 == 3'd5) mn = rvdec_pkg::MN_SRA;
                end
            end
            rvdec_pkg::OPC_REG32: begin
                if ((f3 == 3'd0 || f3 == 3'd5) &&
                    (f7 == rvdec_pkg::F7_BASE || f7 == rvdec_pkg::F7_ALT)) begin
                    mn = rvdec_pkg::MN_WIDE;
                end else if (f3 == 3'd1 && f7 == rvdec_pkg::F7_BASE) begin
                    mn = rvdec_pkg::MN_WIDE;
                end
            end
            default: mn = rvdec_pkg::MN_UNK;
        endcase

        // The immediate follows the format alone, even for unknown mnemonics.
        case (fm)
            rvdec_pkg::FMT_I: d.imm = {{21{word[31]}}, word[30:20]};
            rvdec_pkg::FMT_S: d.imm = {{21{word[31]}}, word[30:25], word[11:7]};
            rvdec_pkg::FMT_B: d.imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
            rvdec_pkg::FMT_U: d.imm = {word[31:12], 12'd0};
            rvdec_pkg::FMT_J: d.imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
            default: d.imm = '0;
        endcase

        d.mnem = mn;
        d.fmt  = fm;
        d.rd   = word[11:7];
        d.rs1  = word[19:15];
        d.rs2  = word[24:20];
        return d;
    endfunction

    function void note_request(logic [31:0] word);
        owed_decodes.push_back(decode_word(word));
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(t_decoded_instr got);
        t_decoded_instr want;
        if (owed_decodes.size() == 0) begin
            $error("result arrived with no request outstanding (mnemonic %0h)", got.mnem);
            errors++;
            return;
        end
        want = owed_decodes.pop_front();
        checked++;
        mnem_seen[want.mnem] = 1'b1;
        compare_field("mnemonic_code", 32'(want.mnem), 32'(got.mnem));
        compare_field("format_class", 32'(want.fmt), 32'(got.fmt));
        compare_field("dest_reg", 32'(want.rd), 32'(got.rd));
        compare_field("src1_reg", 32'(want.rs1), 32'(got.rs1));
        compare_field("src2_reg", 32'(want.rs2), 32'(got.rs2));
        compare_field("immediate", want.imm, got.imm);
    endfunction

    function int unsigned outstanding();
        return owed_decodes.size();
    endfunction

    function int unsigned mnemonics_covered();
        int unsigned n;
        n = 0;
        foreach (mnem_seen[i]) if (mnem_seen[i]) n++;
        return n;
    endfunction
endclass

module testbench;

    // Random words per phase; three phases make up about 2000 requests.
    localparam int unsigned WORDS_PER_PHASE = 660;
    // Far above the slowest legal run of about 2000 requests.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    // Wait after the last owed result, to catch any straggler.
    localparam int unsigned DRAIN_CYCLES    = 10;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_in_valid         = 1'b0;
    logic [31:0]        i_instruction_word = '0;
    logic               i_out_stall        = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [5:0]         o_mnemonic_code;
    logic [2:0]         o_format_class;
    logic [4:0]         o_dest_reg;
    logic [4:0]         o_src1_reg;
    logic [4:0]         o_src2_reg;
    logic signed [31:0] o_immediate;

    t_decode_scoreboard decodes;
    int unsigned        cycle_count    = 0;
    int unsigned        words_sent     = 0;
    int unsigned        send_idle_pct  = 16;
    int unsigned        recv_stall_pct = 83;

    // Hand-picked words: field extremes and the corner cases of the decode.
    logic [31:0] directed_words[$] = '{
        32'h0000_0000,  // unknown opcode, all fields zero
        32'hFFFF_FFFF,  // unknown opcode, all ones: immediate must still be zero
        32'h0000_0073,  // ecall
        32'h0010_0073,  // ebreak
        32'h0020_0073,  // system funct3 zero, other upper bits: unknown
        32'h0000_100F,  // fence.i
        32'hFFF0_C093,  // xori with funct3 four and a negative immediate
        32'h41F0_5013,  // srai, largest shift amount
        32'h0200_1013,  // slli with a nonzero funct7: unknown
        32'h0000_3003,  // 64-bit load (ld)
        32'h0000_6003,  // 64-bit unsigned word load (lwu)
        32'h0000_3023,  // 64-bit store (sd)
        32'hFE00_7FA3,  // store with an unused funct3, negative S immediate
        32'h0000_001B,  // addiw
        32'h0000_201B,  // word-immediate opcode with an unused funct3
        32'h0000_103B,  // sllw
        32'h4000_103B,  // sllw encoding with the alternate funct7: unknown
        32'hFFFF_F0B7,  // lui with every immediate bit set
        32'h8000_00EF,  // jal with the most negative offset
        32'h7FF0_2FE3,  // branch with an unused funct3
        32'h0200_0033,  // mul
        32'h4000_0033,  // sub
        32'h4000_1033,  // register op with the alternate funct7 on sll: unknown
        32'h3400_1073,  // csrrw
        32'h3400_4073,  // system funct3 four: unknown
        32'h0000_1067   // jalr with a nonzero funct3: unknown
    };

    rv32im_instruction_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_instruction_word (i_instruction_word),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_mnemonic_code    (o_mnemonic_code),
        .o_format_class     (o_format_class),
        .o_dest_reg         (o_dest_reg),
        .o_src1_reg         (o_src1_reg),
        .o_src2_reg         (o_src2_reg),
        .o_immediate        (o_immediate)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run-away guard: any hang or lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** rv32im_instruction_decoder: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both handshakes are sampled at the clock edge, ahead of any update the
    // edge itself causes. A request is noted before the result check, which
    // is safe since no result can come back in the cycle of its own request.
    always @(posedge i_clk) begin : handshake_monitor
        t_decoded_instr got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decodes.note_request(i_instruction_word);
            end
            if (o_out_valid && !i_out_stall) begin
                got.mnem = o_mnemonic_code;
                got.fmt  = o_format_class;
                got.rd   = o_dest_reg;
                got.rs1  = o_src1_reg;
                got.rs2  = o_src2_reg;
                got.imm  = o_immediate;
                decodes.check_result(got);
            end
        end
    end

    // Presents one request and holds it until the block takes it, then lets
    // the sender idle for a random number of cycles. Idle cycles carry junk
    // on the word so that a low valid is seen to be honored.
    task automatic send_word(input logic [31:0] word);
        i_in_valid         <= 1'b1;
        i_instruction_word <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid         <= 1'b0;
            i_instruction_word <= $urandom();
            @(posedge i_clk);
        end
    endtask

    // Most random words carry one of the known opcodes so that every decode
    // path is reached; funct7 is pulled toward the values that select
    // something, and system words toward ecall and ebreak. The rest are
    // fully random words, which also toggle every bit of the input.
    function automatic logic [31:0] random_word();
        logic [31:0] word;
        word = $urandom();
        if ($urandom_range(99) < 15) return word;
        case ($urandom_range(12))
            0:  word[6:0] = rvdec_pkg::OPC_LOAD;
            1:  word[6:0] = rvdec_pkg::OPC_MISC;
            2:  word[6:0] = rvdec_pkg::OPC_IMM;
            3:  word[6:0] = rvdec_pkg::OPC_AUIPC;
            4:  word[6:0] = rvdec_pkg::OPC_IMM32;
            5:  word[6:0] = rvdec_pkg::OPC_STORE;
            6:  word[6:0] = rvdec_pkg::OPC_REG;
            7:  word[6:0] = rvdec_pkg::OPC_LUI;
            8:  word[6:0] = rvdec_pkg::OPC_REG32;
            9:  word[6:0] = rvdec_pkg::OPC_BRANCH;
            10: word[6:0] = rvdec_pkg::OPC_JALR;
            11: word[6:0] = rvdec_pkg::OPC_JAL;
            default: word[6:0] = rvdec_pkg::OPC_SYSTEM;
        endcase
        case ($urandom_range(3))
            0: word[31:25] = rvdec_pkg::F7_BASE;
            1: word[31:25] = rvdec_pkg::F7_MULDIV;
            2: word[31:25] = rvdec_pkg::F7_ALT;
            default: ;
        endcase
        if (word[6:0] == rvdec_pkg::OPC_SYSTEM && word[14:12] == 3'd0 &&
            $urandom_range(2) != 0) begin
            word[31:20] = $urandom_range(1) ? rvdec_pkg::SYS_EBREAK : rvdec_pkg::SYS_ECALL;
        end
        return word;
    endfunction

    initial begin
        decodes = new();

        // Synchronous reset held from the start, released once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender mostly busy, receiver mostly stalled.
        send_idle_pct   = 16;
        recv_stall_pct <= 83;
        foreach (directed_words[i]) send_word(directed_words[i]);
        repeat (WORDS_PER_PHASE) send_word(random_word());

        // Phase two: the other way round.
        send_idle_pct   = 83;
        recv_stall_pct <= 16;
        repeat (WORDS_PER_PHASE) send_word(random_word());

        // Phase three: back-to-back requests with no stalls at all.
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        repeat (WORDS_PER_PHASE) send_word(random_word());
        i_in_valid <= 1'b0;

        // Wait for every owed result, then a few cycles to catch extras.
        while (decodes.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d instruction words (%0d hand-picked), checked %0d decodes.",
                 words_sent, directed_words.size(), decodes.checked);
        $display("Expected mnemonic codes covered: %0d of 57; mismatches: %0d.",
                 decodes.mnemonics_covered(), decodes.errors);
        if (decodes.errors == 0) begin
            $display("** rv32im_instruction_decoder: PASSED **");
        end else begin
            $display("** rv32im_instruction_decoder: FAILED **");
        end
        $finish;
    end

endmodule

>>> rv32im_instruction_decoder.f
hdl/rvdec_pkg.sv
hdl/rvdec_mnem.sv
hdl/rvdec_imm.sv
hdl/rv32im_instruction_decoder.sv
test/testbench.sv
